/* rtl/srsf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsf_pkg
// Shared types, codes and helpers for the signed radix symbol formatter.
// ----------------------------------------------------------------------------
package srsf_pkg;

  // sign characters
  localparam logic [7:0] SYM_MINUS = 8'h2D;
  localparam logic [7:0] SYM_PLUS  = 8'h2B;

  // register map (index of each 64-bit register, byte address is 8 * index)
  localparam int         ADDR_W      = 5;
  localparam logic [1:0] REG_SYM_LO  = 2'd0;
  localparam logic [1:0] REG_SYM_HI  = 2'd1;
  localparam logic [1:0] REG_RADIX   = 2'd2;

  // widths that do not vary
  localparam int RADIX_W  = 5;   // radix register width
  localparam int SYM_W    = 8;   // one symbol byte
  localparam int NUM_SLOT = 32;  // slots a 5-bit radix can reach
  localparam int DIG_STEP = 8;   // quotient bits resolved per divide cycle

  // sequencer states
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_SIGN  = 6'b001000,
    ST_READ  = 6'b010000,
    ST_SHOW  = 6'b100000
  } state_t;

  // symbol slot lookup; slots sixteen and above read as zero
  function automatic logic [SYM_W-1:0] sym_at(input logic [63:0] lo,
                                               input logic [63:0] hi,
                                               input logic [RADIX_W-1:0] idx);
    logic [SYM_W-1:0] s;
    if (idx[4]) begin
      s = '0;
    end else if (idx[3]) begin
      s = hi[{idx[2:0], 3'b000} +: SYM_W];
    end else begin
      s = lo[{idx[2:0], 3'b000} +: SYM_W];
    end
    return s;
  endfunction

endpackage

/* rtl/signed_radix_symbol_formatter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_radix_symbol_formatter
// Formats a signed value as text in the radix of a configured alphabet,
// one symbol byte per output transfer, most significant digit first.
// ----------------------------------------------------------------------------
// Sequence: an alphabet check, one slot at a time, then each digit in the
//   shared divider (8 quotient bits per cycle).
// Throughput: one value at a time; each digit symbol passes through the
//   registered digit memory read port (ST_READ, then ST_SHOW) to be emitted.
// Reset: synchronous active-low rst_n clears the sequencer, the output valid
//   and the configuration registers; the digit memory is not cleared.
module signed_radix_symbol_formatter #(
  parameter int MAX_RADIX  = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [VALUE_BITS-1:0]        in_value,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [srsf_pkg::SYM_W-1:0]          out_symbol,
  output logic                                out_last,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [srsf_pkg::ADDR_W-1:0]         paddr,
  input  logic [63:0]                         pwdata,
  output logic [63:0]                         prdata,
  output logic                                pready
);
  import srsf_pkg::*;

  localparam int DIV_CYC = (VALUE_BITS + DIG_STEP - 1) / DIG_STEP;
  localparam int MAG_W   = DIV_CYC * DIG_STEP;
  localparam int DCW     = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
  localparam int AW      = $clog2(VALUE_BITS);
  localparam logic [6:0]     MAX_RADIX_V = 7'(MAX_RADIX);
  localparam logic [DCW-1:0] DCYC_LAST   = DCW'(DIV_CYC - 1);

  // configuration registers
  logic [63:0]         sym_lo_r, sym_hi_r;
  logic [RADIX_W-1:0]  radix_r;

  // sequencer and datapath registers
  state_t              state_r, state_nxt;
  logic                neg_r, neg_nxt;
  logic [MAG_W-1:0]    mag_r, mag_nxt;
  logic [RADIX_W-1:0]  rem_r, rem_nxt;
  logic [DCW-1:0]      dcyc_r, dcyc_nxt;
  logic [RADIX_W-1:0]  chk_r, chk_nxt;
  logic [AW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]    out_symbol_r, out_symbol_nxt;
  logic                out_last_r, out_last_nxt;

  // digit memory
  logic [SYM_W-1:0]    mem [VALUE_BITS];
  logic [SYM_W-1:0]    rd_data_r;
  logic                mem_we;
  logic [SYM_W-1:0]    mem_wdata;

  // misc combinational
  logic                cfg_wr;
  logic [VALUE_BITS-1:0] abs_val;
  logic [SYM_W-1:0]    chk_sym;
  logic                dup_hit;
  logic                sym_bad;
  logic                range_bad;
  logic [MAG_W-1:0]    mag_div;
  logic [RADIX_W-1:0]  rem_div;
  logic                out_room;

  // configuration write and read
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_lo_r <= '0;
      sym_hi_r <= '0;
      radix_r  <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[4:3])
        REG_SYM_LO: sym_lo_r <= pwdata;
        REG_SYM_HI: sym_hi_r <= pwdata;
        REG_RADIX:  radix_r  <= pwdata[RADIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_SYM_LO: prdata = sym_lo_r;
      REG_SYM_HI: prdata = sym_hi_r;
      REG_RADIX:  prdata = {{(64-RADIX_W){1'b0}}, radix_r};
      default:    prdata = '0;
    endcase
  end

  // magnitude of the incoming value
  assign abs_val = in_value[VALUE_BITS-1] ? (~in_value + 1'b1) : in_value;

  // alphabet check: one slot against all others per cycle
  assign chk_sym   = sym_at(sym_lo_r, sym_hi_r, chk_r);
  assign range_bad = (radix_r < RADIX_W'(2)) || ({2'b00, radix_r} > MAX_RADIX_V);

  always_comb begin
    dup_hit = 1'b0;
    for (int b = 0; b < NUM_SLOT; b++) begin
      if ((RADIX_W'(b) < radix_r) && (RADIX_W'(b) != chk_r) &&
          (sym_at(sym_lo_r, sym_hi_r, RADIX_W'(b)) == chk_sym)) begin
        dup_hit = 1'b1;
      end
    end
  end

  assign sym_bad = dup_hit || (chk_sym == SYM_MINUS) || (chk_sym == SYM_PLUS);

  // shared divider: eight restoring steps per cycle on a narrow remainder
  always_comb begin
    logic [RADIX_W:0]   t;
    logic [RADIX_W-1:0] r;
    logic [DIG_STEP-1:0] bits;
    logic [DIG_STEP-1:0] q;
    r    = rem_r;
    bits = mag_r[MAG_W-1 -: DIG_STEP];
    q    = '0;
    for (int i = DIG_STEP - 1; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, radix_r}) begin
        q[i] = 1'b1;
        t    = t - {1'b0, radix_r};
      end
      r = t[RADIX_W-1:0];
    end
    rem_div = r;
    mag_div = (mag_r << DIG_STEP) | MAG_W'(q);
  end

  assign out_room = !out_valid_r || out_ready;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    neg_nxt        = neg_r;
    mag_nxt        = mag_r;
    rem_nxt        = rem_r;
    dcyc_nxt       = dcyc_r;
    chk_nxt        = chk_r;
    wr_ptr_nxt     = wr_ptr_r;
    rd_ptr_nxt     = rd_ptr_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_symbol_nxt = out_symbol_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_wdata      = sym_at(sym_lo_r, sym_hi_r, rem_div);

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          neg_nxt    = in_value[VALUE_BITS-1];
          mag_nxt    = MAG_W'(abs_val);
          rem_nxt    = '0;
          dcyc_nxt   = '0;
          chk_nxt    = '0;
          wr_ptr_nxt = '0;
          state_nxt  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (range_bad || sym_bad) begin
          state_nxt = ST_IDLE;
        end else if (chk_r == radix_r - RADIX_W'(1)) begin
          state_nxt = ST_DIV;
        end else begin
          chk_nxt = chk_r + RADIX_W'(1);
        end
      end
      ST_DIV: begin
        mag_nxt = mag_div;
        rem_nxt = rem_div;
        if (dcyc_r == DCYC_LAST) begin
          mem_we     = 1'b1;
          rem_nxt    = '0;
          dcyc_nxt   = '0;
          wr_ptr_nxt = wr_ptr_r + AW'(1);
          if (mag_div == '0) begin
            rd_ptr_nxt = wr_ptr_r;
            state_nxt  = ST_SIGN;
          end
        end else begin
          dcyc_nxt = dcyc_r + DCW'(1);
        end
      end
      ST_SIGN: begin
        if (!neg_r) begin
          state_nxt = ST_READ;
        end else if (out_room) begin
          out_valid_nxt  = 1'b1;
          out_symbol_nxt = SYM_MINUS;
          out_last_nxt   = 1'b0;
          state_nxt      = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_SHOW;
      end
      ST_SHOW: begin
        if (out_room) begin
          out_valid_nxt  = 1'b1;
          out_symbol_nxt = rd_data_r;
          out_last_nxt   = (rd_ptr_r == '0);
          if (rd_ptr_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            rd_ptr_nxt = rd_ptr_r - AW'(1);
            state_nxt  = ST_READ;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    neg_r        <= neg_nxt;
    mag_r        <= mag_nxt;
    rem_r        <= rem_nxt;
    dcyc_r       <= dcyc_nxt;
    chk_r        <= chk_nxt;
    wr_ptr_r     <= wr_ptr_nxt;
    rd_ptr_r     <= rd_ptr_nxt;
    out_symbol_r <= out_symbol_nxt;
    out_last_r   <= out_last_nxt;
  end

  // digit memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_ptr_r] <= mem_wdata;
    end
    rd_data_r <= mem[rd_ptr_r];
  end

  assign in_ready   = (state_r == ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_last   = out_last_r;

endmodule

/* rtl/srsf_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsf_checker
// Port-level checks for the signed radix symbol formatter, bound to the top.
// ----------------------------------------------------------------------------
module srsf_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [srsf_pkg::SYM_W-1:0] out_symbol,
  input logic                       out_last
);
  import srsf_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_symbol) && $stable(out_last))
    else $error("result changed while stalled");

  // one request at a time: ready drops after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // the result channel goes idle once the final symbol is taken
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid)
    else $error("symbol after end of run");

  // a minus sign never closes a run
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_symbol == SYM_MINUS) |-> !out_last)
    else $error("minus sign marked last");

endmodule

bind signed_radix_symbol_formatter srsf_checker u_srsf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_symbol (out_symbol),
  .out_last   (out_last)
);
